// ----- design/acia_tape_serial_port_unit_assert.svh -----
// Assertion macros for the tape serial port unit.
// Both macros expect clk and rst_n in scope.
`ifndef ACIA_TAPE_SERIAL_PORT_UNIT_ASSERT_SVH
`define ACIA_TAPE_SERIAL_PORT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ACIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/acia_pkg.sv -----
package acia_pkg;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int RATIO_W  = 24;
    localparam int ACC_W    = 32;
    localparam int DIV_W    = 7;
    localparam int BITS_W   = 4;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd13653333;

    // operation codes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;

    // address bit 0
    localparam logic REG_CTRL = 1'b0;
    localparam logic REG_DATA = 1'b1;

    // control divider select
    localparam logic [1:0] DIV_SEL_1     = 2'd0;
    localparam logic [1:0] DIV_SEL_16    = 2'd1;
    localparam logic [1:0] DIV_SEL_64    = 2'd2;
    localparam logic [1:0] DIV_SEL_RESET = 2'd3;

    localparam logic [DIV_W-1:0] DIV_1  = 7'd1;
    localparam logic [DIV_W-1:0] DIV_16 = 7'd16;
    localparam logic [DIV_W-1:0] DIV_64 = 7'd64;

    // status bit positions
    localparam int ST_RDRF = 0;
    localparam int ST_TDRE = 1;
    localparam int ST_FE   = 4;
    localparam int ST_OVRN = 5;

    localparam logic [BITS_W-1:0] FRAME_LONG  = 4'd11;
    localparam logic [BITS_W-1:0] FRAME_SHORT = 4'd10;

    // Lowest field last, so the packed order matches the tdata layout.
    typedef struct packed {
        logic [4:0] pad;
        logic       tape_out_ready;
        logic [7:0] tape_in_byte;
        logic       tape_in_valid;
        logic [7:0] elapsed_cycles;
        logic [7:0] write_data;
        logic       reg_select;
    } item_t;

    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] tape_out_byte;
        logic       tape_out_valid;
        logic       tape_in_take;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic             advance;
        logic [7:0]       elapsed;
        logic             load;
        logic [DIV_W-1:0] divider;
    } baud_ctrl_t;

    function automatic logic [BITS_W-1:0] frame_of_ws(input logic [2:0] ws);
        logic [BITS_W-1:0] bits;
        unique case (ws)
            3'd2, 3'd3, 3'd5: bits = FRAME_SHORT;
            default:          bits = FRAME_LONG;
        endcase
        return bits;
    endfunction

endpackage

// ----- design/acia_baud.sv -----
module acia_baud (
    input  logic                            clk,
    input  logic                            rst_n,
    input  acia_pkg::baud_ctrl_t            ctrl,
    input  logic [acia_pkg::RATIO_W-1:0]    ratio,
    output logic                            bit_time
);
    import acia_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DIV_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0] div_reg, div_next;

    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sat;
    logic [ACC_W:0]   diff;
    logic             tick;
    logic [DIV_W-1:0] count_dec;

    // saturating add of cycles << 16, then one ratio subtract
    assign sum  = {1'b0, acc_reg} + {9'd0, ctrl.elapsed, 16'd0};
    assign sat  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    assign diff = {1'b0, sat} - {{(ACC_W+1-RATIO_W){1'b0}}, ratio};
    assign tick = ~diff[ACC_W];
    assign count_dec = count_reg - DIV_W'(1);

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        div_next   = div_reg;
        bit_time   = 1'b0;
        if (ctrl.advance)
        begin
            acc_next = tick ? diff[ACC_W-1:0] : sat;
            if (tick)
            begin
                count_next = (count_dec == '0) ? div_reg : count_dec;
                bit_time   = (count_dec == '0);
            end
        end
        else if (ctrl.load)
        begin
            div_next   = ctrl.divider;
            count_next = ctrl.divider;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= DIV_1;
            div_reg   <= DIV_1;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            div_reg   <= div_next;
        end
    end

endmodule

// ----- design/acia_tape_serial_port_unit.sv -----
// Channel      | Dir | Payload
// s_*          | in  | tdata: reg_select, write_data, elapsed_cycles, tape_in_valid,
//              |     |        tape_in_byte, tape_out_ready; tuser: operation
// m_*          | out | tdata: read_data, tape_in_take, tape_out_valid, tape_out_byte
// cfg_*        | in  | clock_ratio, Q8.16, written when cfg_we is high
//
// One transaction per clock sustained while m_tready stays high: an accepted item
// sits in the input register, its step is evaluated there against the port state
// and lands in the result register, which drives m_tvalid and m_tdata.
// The next item sees the state left by the previous one with no bubble.
// A stall on m_* backs up into s_tready only once both registers are full.
// rst_n is asynchronous, active low; it restores clock_ratio and all port state.
`include "acia_tape_serial_port_unit_assert.svh"

module acia_tape_serial_port_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] reg_select, [8:1] write_data, [16:9] elapsed_cycles, [17] tape_in_valid,
    // [25:18] tape_in_byte, [26] tape_out_ready, [31:27] zero
    input  logic [acia_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  logic [acia_pkg::S_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] read_data, [8] tape_in_take, [9] tape_out_valid, [17:10] tape_out_byte,
    // [23:18] zero
    output logic [acia_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_we,
    input  logic [acia_pkg::RATIO_W-1:0]     cfg_wdata
);
    import acia_pkg::*;

    // pipeline registers
    logic                in_vld_reg;
    item_t               in_reg;
    logic [1:0]          op_reg;
    logic                out_vld_reg;
    result_t             out_reg;

    // port state
    logic [RATIO_W-1:0]  ratio_reg;
    logic [BITS_W-1:0]   rx_left_reg, rx_left_next;
    logic [BITS_W-1:0]   tx_left_reg, tx_left_next;
    logic [BITS_W-1:0]   frame_reg, frame_next;
    logic                started_reg, started_next;
    logic [7:0]          status_reg, status_next;
    logic [7:0]          rx_data_reg, rx_data_next;
    logic [7:0]          tx_data_reg, tx_data_next;

    logic                out_free;
    logic                step;
    logic                bit_time;
    baud_ctrl_t          baud_ctrl;
    result_t             res;

    assign out_free = ~out_vld_reg | m_tready;
    assign s_tready = ~in_vld_reg | out_free;
    assign step     = in_vld_reg & out_free;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // timer chain only moves on an advance; divider loads on a control write other than master reset
    always_comb
    begin
        baud_ctrl.advance = step & (op_reg == OP_ADVANCE);
        baud_ctrl.elapsed = in_reg.elapsed_cycles;
        baud_ctrl.load    = step & (op_reg == OP_WRITE) & (in_reg.reg_select == REG_CTRL)
                          & (in_reg.write_data[1:0] != DIV_SEL_RESET);
        unique case (in_reg.write_data[1:0])
            DIV_SEL_16: baud_ctrl.divider = DIV_16;
            DIV_SEL_64: baud_ctrl.divider = DIV_64;
            default:    baud_ctrl.divider = DIV_1;
        endcase
    end

    acia_baud u_baud (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (baud_ctrl),
        .ratio    (ratio_reg),
        .bit_time (bit_time)
    );

    always_comb
    begin
        rx_left_next = rx_left_reg;
        tx_left_next = tx_left_reg;
        frame_next   = frame_reg;
        started_next = started_reg;
        status_next  = status_reg;
        rx_data_next = rx_data_reg;
        tx_data_next = tx_data_reg;
        res          = '0;

        if (step)
        begin
            unique case (op_reg)
                OP_ADVANCE:
                begin
                    if (bit_time && started_reg)
                    begin
                        // receive framer
                        if (rx_left_reg != '0)
                            rx_left_next = rx_left_reg - BITS_W'(1);
                        else if (!status_reg[ST_RDRF] && in_reg.tape_in_valid)
                        begin
                            status_next[ST_FE]   = 1'b0;
                            status_next[ST_OVRN] = 1'b0;
                            status_next[ST_RDRF] = 1'b1;
                            rx_data_next         = in_reg.tape_in_byte;
                            rx_left_next         = frame_reg - BITS_W'(1);
                            res.tape_in_take     = 1'b1;
                        end
                        // transmit framer
                        if (tx_left_reg != '0)
                            tx_left_next = tx_left_reg - BITS_W'(1);
                        else if (!status_reg[ST_TDRE] && in_reg.tape_out_ready)
                        begin
                            res.tape_out_valid   = 1'b1;
                            res.tape_out_byte    = tx_data_reg;
                            status_next[ST_TDRE] = 1'b1;
                            tx_left_next         = frame_reg - BITS_W'(1);
                        end
                    end
                end
                OP_READ:
                begin
                    started_next = 1'b1;
                    if (in_reg.reg_select == REG_CTRL)
                        res.read_data = status_reg;
                    else
                    begin
                        res.read_data        = rx_data_reg;
                        status_next[ST_RDRF] = 1'b0;
                        status_next[ST_OVRN] = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (in_reg.reg_select == REG_CTRL)
                    begin
                        // master reset: status back to transmitter empty only
                        if (in_reg.write_data[1:0] == DIV_SEL_RESET)
                        begin
                            status_next          = '0;
                            status_next[ST_TDRE] = 1'b1;
                        end
                        frame_next = frame_of_ws(in_reg.write_data[4:2]);
                    end
                    else
                    begin
                        tx_data_next         = in_reg.write_data;
                        status_next[ST_TDRE] = 1'b0;
                    end
                end
                default:
                begin
                    // unused code: no effect, all-zero result
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            ratio_reg   <= RATIO_RESET;
            rx_left_reg <= '0;
            tx_left_reg <= '0;
            frame_reg   <= FRAME_LONG;
            started_reg <= 1'b0;
            status_reg  <= '0;
            rx_data_reg <= '0;
            tx_data_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (out_free)
                out_vld_reg <= in_vld_reg;
            if (cfg_we)
                ratio_reg <= cfg_wdata;
            rx_left_reg <= rx_left_next;
            tx_left_reg <= tx_left_next;
            frame_reg   <= frame_next;
            started_reg <= started_next;
            status_reg  <= status_next;
            rx_data_reg <= rx_data_next;
            tx_data_reg <= tx_data_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= item_t'(s_tdata);
            op_reg <= s_tuser;
        end
        if (step)
            out_reg <= res;
    end

    `ACIA_ASSERT_NEXT(a_take_sets_rdrf, step && res.tape_in_take,
        status_reg[ST_RDRF], "byte taken from tape but RDRF not set")
    `ACIA_ASSERT_NEXT(a_emit_sets_tdre, step && res.tape_out_valid,
        status_reg[ST_TDRE], "byte emitted to tape but TDRE not set")
    `ACIA_ASSERT_NOW(a_backpressure_only_when_full, !s_tready,
        in_vld_reg && out_vld_reg && !m_tready, "s_tready low with a free stage")

endmodule

// ----- dv/tb_acia_tape_serial_port_unit.sv -----
`timescale 1ns / 1ps

// Testbench for the tape serial port unit.
// A cycle-level predictor tracks the port state for every accepted bus step.
// Each response is checked against the oldest prediction.
module tb_acia_tape_serial_port_unit;
    import acia_pkg::*;

    // operation code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // word-select codes (control bits 4:2); 7E1, 7O1 and 8N1 give the short frame
    localparam logic [2:0] WS_7E2 = 3'd0;
    localparam logic [2:0] WS_7E1 = 3'd2;
    localparam logic [2:0] WS_7O1 = 3'd3;
    localparam logic [2:0] WS_8N1 = 3'd5;
    localparam logic [2:0] WS_8O1 = 3'd7;

    localparam int LATENCY        = 2;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int NUM_PHASES     = 5;

    // Port predictor plus the queue of responses still owed by the block.
    class port_response_board;
        logic [RATIO_W-1:0] ratio;
        logic [ACC_W-1:0]   accum;
        logic [DIV_W-1:0]   countdown;
        logic [DIV_W-1:0]   divider;
        logic [BITS_W-1:0]  rx_left;
        logic [BITS_W-1:0]  tx_left;
        logic [BITS_W-1:0]  frame_len;
        bit                 started;
        logic [7:0]         status;
        logic [7:0]         rx_byte;
        logic [7:0]         tx_byte;
        result_t            pending_responses[$];
        int                 errors;

        function new();
            ratio     = RATIO_RESET;
            accum     = '0;
            countdown = DIV_1;
            divider   = DIV_1;
            rx_left   = '0;
            tx_left   = '0;
            frame_len = FRAME_LONG;
            started   = 1'b0;
            status    = '0;
            rx_byte   = '0;
            tx_byte   = '0;
            errors    = 0;
        endfunction

        // Advance the predicted state by one accepted step, queue its response.
        function void note_bus_step(logic [1:0] op, item_t it);
            result_t         r;
            logic [ACC_W:0]  sum;
            r = '0;
            case (op)
                OP_ADVANCE:
                begin
                    sum = {1'b0, accum} + {9'd0, it.elapsed_cycles, 16'd0};
                    accum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    if (accum >= {8'd0, ratio})
                    begin
                        accum = accum - {8'd0, ratio};
                        countdown = countdown - 1'b1;
                        if (countdown == '0)
                        begin
                            countdown = divider;
                            if (started)
                            begin
                                // receive framer first; it never touches TDRE
                                if (rx_left != '0)
                                    rx_left = rx_left - 1'b1;
                                else if (!status[ST_RDRF] && it.tape_in_valid)
                                begin
                                    status[ST_FE]   = 1'b0;
                                    status[ST_OVRN] = 1'b0;
                                    status[ST_RDRF] = 1'b1;
                                    rx_byte = it.tape_in_byte;
                                    rx_left = frame_len - 1'b1;
                                    r.tape_in_take = 1'b1;
                                end
                                if (tx_left != '0)
                                    tx_left = tx_left - 1'b1;
                                else if (!status[ST_TDRE] && it.tape_out_ready)
                                begin
                                    r.tape_out_valid = 1'b1;
                                    r.tape_out_byte  = tx_byte;
                                    status[ST_TDRE]  = 1'b1;
                                    tx_left = frame_len - 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    started = 1'b1;
                    if (it.reg_select == REG_CTRL)
                        r.read_data = status;
                    else
                    begin
                        r.read_data = rx_byte;
                        status[ST_RDRF] = 1'b0;
                        status[ST_OVRN] = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (it.reg_select == REG_CTRL)
                    begin
                        case (it.write_data[1:0])
                            DIV_SEL_1:
                            begin
                                divider   = DIV_1;
                                countdown = DIV_1;
                            end
                            DIV_SEL_16:
                            begin
                                divider   = DIV_16;
                                countdown = DIV_16;
                            end
                            DIV_SEL_64:
                            begin
                                divider   = DIV_64;
                                countdown = DIV_64;
                            end
                            default:
                            begin
                                // master reset: only TDRE survives, divider kept
                                status = '0;
                                status[ST_TDRE] = 1'b1;
                            end
                        endcase
                        case (it.write_data[4:2])
                            WS_7E1, WS_7O1, WS_8N1: frame_len = FRAME_SHORT;
                            default:                frame_len = FRAME_LONG;
                        endcase
                    end
                    else
                    begin
                        tx_byte = it.write_data;
                        status[ST_TDRE] = 1'b0;
                    end
                end
                default: ;
            endcase
            pending_responses.push_back(r);
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with none pending, expected nothing, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $display("%0t: read_data expected %h, got %h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.tape_in_take !== want.tape_in_take)
            begin
                $display("%0t: tape_in_take expected %b, got %b",
                         $time, want.tape_in_take, got.tape_in_take);
                errors++;
            end
            if (got.tape_out_valid !== want.tape_out_valid)
            begin
                $display("%0t: tape_out_valid expected %b, got %b",
                         $time, want.tape_out_valid, got.tape_out_valid);
                errors++;
            end
            if (got.tape_out_byte !== want.tape_out_byte)
            begin
                $display("%0t: tape_out_byte expected %h, got %h",
                         $time, want.tape_out_byte, got.tape_out_byte);
                errors++;
            end
            if (got.pad !== want.pad)
            begin
                $display("%0t: tdata pad expected %h, got %h", $time, want.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [S_USER_W-1:0] s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [RATIO_W-1:0]  cfg_wdata = '0;

    port_response_board board;

    // idling switches, flipped in stretches by the stimulus; off in the last phase
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    // one-shot request for a long sink stall
    bit  rx_hold_req = 1'b0;
    int  cycle_count = 0;

    acia_tape_serial_port_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Transactions are taken at the rising edge; drivers only move on the falling edge,
    // so the values seen here are the settled pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_bus_step(s_tuser, item_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            board.check_response(result_t'(m_tdata));
    end

    // Response sink: random ready bursts, plus one long hold on request.
    initial
    begin : response_sink
        int held;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++)
                    @(negedge clk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic item_t make_item(input logic sel, input logic [7:0] wd,
                                        input logic [7:0] cycles, input logic in_valid,
                                        input logic [7:0] in_byte, input logic out_ready);
        item_t it;
        it = '0;
        it.reg_select     = sel;
        it.write_data     = wd;
        it.elapsed_cycles = cycles;
        it.tape_in_valid  = in_valid;
        it.tape_in_byte   = in_byte;
        it.tape_out_ready = out_ready;
        return it;
    endfunction

    // Mostly CPU-like traffic: time advances, status polls, data reads and writes,
    // occasional control writes and the odd unused opcode. Payload bits stay random.
    function automatic void random_step(input int adv_pct, output logic [1:0] op,
                                        output item_t it);
        int pick;
        int div_pick;
        it = item_t'($urandom);
        it.pad = '0;
        pick = $urandom_range(0, 99);
        if (pick < adv_pct)
        begin
            op = OP_ADVANCE;
            if ($urandom_range(0, 1) == 0)
                it.elapsed_cycles = 8'hFF;
            it.tape_in_valid  = ($urandom_range(0, 3) != 0);
            it.tape_out_ready = ($urandom_range(0, 3) != 0);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                op = OP_READ;
                it.reg_select = REG_CTRL;
            end
            else if (pick < 65)
            begin
                op = OP_READ;
                it.reg_select = REG_DATA;
            end
            else if (pick < 85)
            begin
                op = OP_WRITE;
                it.reg_select = REG_DATA;
            end
            else if (pick < 97)
            begin
                op = OP_WRITE;
                it.reg_select = REG_CTRL;
                div_pick = $urandom_range(0, 9);
                if (div_pick < 6)
                    it.write_data[1:0] = DIV_SEL_1;
                else if (div_pick < 8)
                    it.write_data[1:0] = DIV_SEL_RESET;
                else if (div_pick == 8)
                    it.write_data[1:0] = DIV_SEL_16;
                else
                    it.write_data[1:0] = DIV_SEL_64;
            end
            else
                op = OP_UNUSED;
        end
    endfunction

    // Called on a falling edge; returns on the falling edge after acceptance
    // with tvalid still high, so back-to-back calls keep the bus busy.
    task automatic offer(input logic [1:0] op, input item_t it);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Every step yields a response, so an empty queue means the pipe is empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_responses.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.ratio = value;
    endtask

    initial
    begin : stimulus
        logic [1:0]          op;
        item_t               it;
        logic [RATIO_W-1:0]  ratio;
        int                  n;
        int                  p;
        int                  items;
        int                  adv_pct;

        board = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part, reset clock ratio ----
        // base tick before any read: countdown moves, framers stay quiet
        offer(OP_ADVANCE, make_item(REG_CTRL, 8'h00, 8'hFF, 1'b1, 8'h81, 1'b1));
        // first read starts the port
        offer(OP_READ, make_item(REG_CTRL, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_WRITE, make_item(REG_DATA, 8'h5A, 8'h00, 1'b0, 8'h00, 1'b0));
        // one bit time: byte taken from tape and TDR emitted in the same step
        offer(OP_ADVANCE, make_item(REG_DATA, 8'h00, 8'hFF, 1'b1, 8'hFF, 1'b1));
        // zero elapsed cycles
        offer(OP_ADVANCE, make_item(REG_CTRL, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1));
        offer(OP_READ, make_item(REG_CTRL, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_READ, make_item(REG_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_WRITE, make_item(REG_DATA, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
        // run both frames out; the next byte is taken once the receiver is idle
        for (n = 0; n < 10; n++)
            offer(OP_ADVANCE, make_item(REG_DATA, 8'hA5, 8'hFF, 1'b1, 8'(n + 8'h30), 1'b1));
        offer(OP_READ, make_item(REG_CTRL, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        // master reset, then each divider and both frame lengths
        offer(OP_WRITE, make_item(REG_CTRL, {3'b000, WS_7E2, DIV_SEL_RESET},
                                  8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_WRITE, make_item(REG_CTRL, {3'b000, WS_8N1, DIV_SEL_16},
                                  8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_WRITE, make_item(REG_CTRL, {3'b111, WS_8O1, DIV_SEL_64},
                                  8'h00, 1'b0, 8'h00, 1'b0));
        offer(OP_WRITE, make_item(REG_CTRL, {3'b000, WS_7E1, DIV_SEL_1},
                                  8'h00, 1'b0, 8'h00, 1'b0));
        // unused opcode with every payload bit set
        offer(OP_UNUSED, make_item(REG_DATA, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
        offer(OP_READ, make_item(REG_DATA, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b1));
        // advance with no tape partner on either side
        offer(OP_ADVANCE, make_item(REG_CTRL, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0));

        // ---- random phases, one clock ratio each ----
        // phase 1 uses a ratio of 1.0 with heavy advances so the accumulator
        // saturates; phase 3 covers the zero-ratio case; the last phase never idles
        for (p = 0; p < NUM_PHASES; p++)
        begin
            adv_pct = 60;
            items   = 300;
            case (p)
                0: ratio = RATIO_RESET;
                1:
                begin
                    ratio   = 24'd65536;
                    adv_pct = 85;
                    items   = 450;
                end
                2: ratio = 24'hFFFFFF;
                3:
                begin
                    ratio = '0;
                    items = 250;
                end
                default: ratio = RATIO_W'($urandom_range(65536, 24'hFFFFFF));
            endcase
            write_ratio(ratio);
            tx_idle_on = (p != NUM_PHASES - 1);
            rx_idle_on = (p != NUM_PHASES - 1);
            for (n = 0; n < items; n++)
            begin
                if (p != NUM_PHASES - 1 && n % 50 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                // long sink stall while the source keeps offering: pipe fills, s_tready drops
                if (p == 1 && n == 100)
                    rx_hold_req = 1'b1;
                // source pause until every response is back
                if (p == 2 && n == 150)
                    wait_drained();
                random_step(adv_pct, op, it);
                offer(op, it);
            end
        end

        wait_drained();
        if (board.errors == 0 && board.pending_responses.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
